/* hdl/aarm_pkg.sv */
package aarm_pkg;

    // Squared axis length is exact in 32 bits; the root works on it shifted up by 16.
    localparam int Q_W         = 32;
    localparam int SQ_IN_W     = Q_W + 16;
    localparam int ROOT_W      = SQ_IN_W / 2;
    localparam int SQRT_STAGES = ROOT_W;
    localparam int SQ_REM_W    = ROOT_W + 2;

    // Reciprocal 2^46 / L with L >= 256 gives at most 39 quotient bits.
    localparam int QUO_W       = 39;
    localparam int DIV_STAGES  = QUO_W;
    localparam logic [ROOT_W-1:0] RECIP_SEED = 24'd128;

    localparam logic [Q_W-1:0] ONE_Q26 = 32'd67108864;
    localparam logic signed [31:0] CORDIC_GAIN = 32'sd652032874;
    localparam int ATAN_ENTRIES = 24;

    localparam logic [15:0] TOL_RESET = 16'd64;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = QPTR_W + 1;

    typedef struct packed {
        logic signed [15:0] ax;
        logic signed [15:0] ay;
        logic signed [15:0] az;
        logic [Q_W-1:0]     q;
        logic signed [31:0] z;
        logic               fold;
        logic               zero;
        logic               unit;
    } item_t;

    // Arctangent of 2^-i as a fraction of a turn, full turn = 2^32.
    function automatic logic signed [31:0] atan_angle(input int i);
        case (i)
            0:       atan_angle = 32'sh20000000;
            1:       atan_angle = 32'sh12E4051E;
            2:       atan_angle = 32'sh09FB385B;
            3:       atan_angle = 32'sh051111D4;
            4:       atan_angle = 32'sh028B0D43;
            5:       atan_angle = 32'sh0145D7E1;
            6:       atan_angle = 32'sh00A2F61E;
            7:       atan_angle = 32'sh00517C55;
            8:       atan_angle = 32'sh0028BE53;
            9:       atan_angle = 32'sh00145F2F;
            10:      atan_angle = 32'sh000A2F98;
            11:      atan_angle = 32'sh000517CC;
            12:      atan_angle = 32'sh00028BE6;
            13:      atan_angle = 32'sh000145F3;
            14:      atan_angle = 32'sh0000A2F9;
            15:      atan_angle = 32'sh0000517C;
            16:      atan_angle = 32'sh000028BE;
            17:      atan_angle = 32'sh0000145F;
            18:      atan_angle = 32'sh00000A2F;
            19:      atan_angle = 32'sh00000517;
            20:      atan_angle = 32'sh0000028B;
            21:      atan_angle = 32'sh00000145;
            22:      atan_angle = 32'sh000000A2;
            23:      atan_angle = 32'sh00000051;
            default: atan_angle = 32'sh00000000;
        endcase
    endfunction

endpackage

/* hdl/axis_angle_rotation_matrix_top.sv */
// An input transfer passes one front stage and the queue, then 24 root, 39 reciprocal
// and 5 product stages, the last of which is the output register.
// One matrix per cycle unless the output stalls; every stage then takes a new transfer.
// A four-entry queue between front and back absorbs output stalls before input backs up.
// Reset (rst_n, asynchronous, active low) empties every stage and the queue and
// sets unit_tolerance to 64; no clearing pass is needed.
module axis_angle_rotation_matrix_top #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_ready,
    input  logic signed [15:0] axis_x,
    input  logic signed [15:0] axis_y,
    input  logic signed [15:0] axis_z,
    input  logic [15:0]        angle,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [15:0]        cfg_data,
    output logic               result_valid,
    input  logic               result_ready,
    output logic signed [17:0] m00,
    output logic signed [17:0] m01,
    output logic signed [17:0] m02,
    output logic signed [17:0] m10,
    output logic signed [17:0] m11,
    output logic signed [17:0] m12,
    output logic signed [17:0] m20,
    output logic signed [17:0] m21,
    output logic signed [17:0] m22,
    output logic               zero_axis
);
    import aarm_pkg::*;

    // The only configuration register. A write transfer is always taken at once.
    logic [15:0] tol_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tol_reg <= TOL_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            tol_reg <= cfg_data;
        end
    end

    // The front registers the axis and its squares, then forms the exact squared length,
    // flags a zero axis, decides whether the axis is already unit length within the
    // tolerance, and folds the angle into a quarter turn either side of zero.
    logic  push_valid;
    logic  push_ready;
    item_t push_item;

    aarm_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .item_valid     (item_valid),
        .item_ready     (item_ready),
        .axis_x         (axis_x),
        .axis_y         (axis_y),
        .axis_z         (axis_z),
        .angle          (angle),
        .unit_tolerance (tol_reg),
        .push_valid     (push_valid),
        .push_ready     (push_ready),
        .push_item      (push_item)
    );

    // Classified items wait here so the front keeps taking transfers while the
    // back pipeline is held by a stalled output.
    logic  pop_valid;
    logic  pop_ready;
    item_t pop_item;

    aarm_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_item   (pop_item)
    );

    // The back runs the square root and the CORDIC side by side, then the reciprocal,
    // the normalization of the components and the Rodrigues products. It moves as one
    // pipeline that advances whenever the output register is free or being read.
    aarm_back #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .pop_valid    (pop_valid),
        .pop_ready    (pop_ready),
        .pop_item     (pop_item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .m00          (m00),
        .m01          (m01),
        .m02          (m02),
        .m10          (m10),
        .m11          (m11),
        .m12          (m12),
        .m20          (m20),
        .m21          (m21),
        .m22          (m22),
        .zero_axis    (zero_axis)
    );

endmodule

/* hdl/aarm_front.sv */
module aarm_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_ready,
    input  logic signed [15:0] axis_x,
    input  logic signed [15:0] axis_y,
    input  logic signed [15:0] axis_z,
    input  logic [15:0]        angle,
    input  logic [15:0]        unit_tolerance,
    output logic               push_valid,
    input  logic               push_ready,
    output aarm_pkg::item_t    push_item
);
    import aarm_pkg::*;

    localparam logic signed [32:0] QUARTER_TURN = 33'sd1073741824;
    localparam logic signed [32:0] HALF_TURN    = 33'sd2147483648;

    logic               a_valid_reg;
    logic signed [15:0] a_x_reg;
    logic signed [15:0] a_y_reg;
    logic signed [15:0] a_z_reg;
    logic [15:0]        a_angle_reg;
    logic [30:0]        a_sqx_reg;
    logic [30:0]        a_sqy_reg;
    logic [30:0]        a_sqz_reg;

    logic signed [31:0] sqx;
    logic signed [31:0] sqy;
    logic signed [31:0] sqz;
    logic [Q_W-1:0]     q;
    logic [Q_W-1:0]     dev;
    logic signed [32:0] zs;
    logic signed [32:0] zf;
    logic               fold;

    assign sqx = axis_x * axis_x;
    assign sqy = axis_y * axis_y;
    assign sqz = axis_z * axis_z;

    assign item_ready = !a_valid_reg || push_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (item_ready)
        begin
            a_valid_reg <= item_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready)
        begin
            a_x_reg     <= axis_x;
            a_y_reg     <= axis_y;
            a_z_reg     <= axis_z;
            a_angle_reg <= angle;
            a_sqx_reg   <= sqx[30:0];
            a_sqy_reg   <= sqy[30:0];
            a_sqz_reg   <= sqz[30:0];
        end
    end

    // Classify: exact squared length, unit test and quarter-turn fold of the angle.
    always_comb
    begin
        q   = {1'b0, a_sqx_reg} + {1'b0, a_sqy_reg} + {1'b0, a_sqz_reg};
        dev = (q >= ONE_Q26) ? (q - ONE_Q26) : (ONE_Q26 - q);
        zs  = {a_angle_reg[15], a_angle_reg, 16'b0};
        zf  = zs;
        fold = 1'b0;
        if (zs > QUARTER_TURN)
        begin
            zf   = zs - HALF_TURN;
            fold = 1'b1;
        end
        else if (zs < -QUARTER_TURN)
        begin
            zf   = zs + HALF_TURN;
            fold = 1'b1;
        end
    end

    assign push_valid     = a_valid_reg;
    assign push_item.ax   = a_x_reg;
    assign push_item.ay   = a_y_reg;
    assign push_item.az   = a_z_reg;
    assign push_item.q    = q;
    assign push_item.z    = zf[31:0];
    assign push_item.fold = fold;
    assign push_item.zero = (q == '0);
    assign push_item.unit = (dev <= {16'b0, unit_tolerance});

endmodule

/* hdl/aarm_queue.sv */
module aarm_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push_valid,
    output logic            push_ready,
    input  aarm_pkg::item_t push_item,
    output logic            pop_valid,
    input  logic            pop_ready,
    output aarm_pkg::item_t pop_item
);
    import aarm_pkg::*;

    item_t             entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic              push;
    logic              pop;

    assign push_ready = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign push       = push_valid && push_ready;
    assign pop        = pop_ready && pop_valid;
    assign pop_item   = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue count exceeds depth");

    a_count_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
        QPTR_W'(count_reg) == QPTR_W'(wr_ptr_reg - rd_ptr_reg))
        else $error("queue count disagrees with pointers");

endmodule

/* hdl/aarm_back.sv */
module aarm_back #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               pop_valid,
    output logic               pop_ready,
    input  aarm_pkg::item_t    pop_item,
    output logic               result_valid,
    input  logic               result_ready,
    output logic signed [17:0] m00,
    output logic signed [17:0] m01,
    output logic signed [17:0] m02,
    output logic signed [17:0] m10,
    output logic signed [17:0] m11,
    output logic signed [17:0] m12,
    output logic signed [17:0] m20,
    output logic signed [17:0] m21,
    output logic signed [17:0] m22,
    output logic               zero_axis
);
    import aarm_pkg::*;

    localparam int CORDIC_ITERS =
        (CORDIC_STEPS < ATAN_ENTRIES) ? CORDIC_STEPS : ATAN_ENTRIES;

    function automatic logic signed [16:0] unit_comp(input logic signed [15:0] a,
                                                     input logic [54:0] p,
                                                     input logic unit);
        logic [54:0] pr;
        logic [16:0] mag;
        pr = p + 55'd4194304;
        if (pr[54:23] > 32'd32768)
        begin
            mag = 17'd32768;
        end
        else
        begin
            mag = pr[39:23];
        end
        if (unit)
        begin
            unit_comp = {a[14:0], 2'b00};
        end
        else if (a[15])
        begin
            unit_comp = -$signed(mag);
        end
        else
        begin
            unit_comp = $signed(mag);
        end
    endfunction

    function automatic logic signed [17:0] finish(input logic signed [37:0] v);
        logic signed [37:0] vr;
        logic signed [22:0] w;
        vr = v + 38'sd16384;
        w  = vr[37:15];
        if (w > 23'sd65536)
        begin
            finish = 18'sd65536;
        end
        else if (w < -23'sd65536)
        begin
            finish = -18'sd65536;
        end
        else
        begin
            finish = w[17:0];
        end
    endfunction

    logic adv;
    assign adv       = !result_valid || result_ready;
    assign pop_ready = adv;

    // Root stages, with the CORDIC iterations running alongside.
    logic                sq_valid_reg [SQRT_STAGES];
    item_t               sq_item_reg  [SQRT_STAGES];
    logic [SQ_REM_W-1:0] sq_rem_reg   [SQRT_STAGES];
    logic [ROOT_W-1:0]   sq_root_reg  [SQRT_STAGES];
    logic signed [31:0]  cx_reg       [SQRT_STAGES];
    logic signed [31:0]  cy_reg       [SQRT_STAGES];
    logic signed [31:0]  cz_reg       [SQRT_STAGES];

    for (genvar k = 0; k < SQRT_STAGES; k++)
    begin : g_sqrt
        localparam int PAIR_HI = SQ_IN_W - 1 - 2 * k;
        logic                st_valid;
        item_t               st_item;
        logic [SQ_REM_W-1:0] rin;
        logic [ROOT_W-1:0]   root_in;
        logic signed [31:0]  cxi;
        logic signed [31:0]  cyi;
        logic signed [31:0]  czi;
        logic [SQ_IN_W-1:0]  v;
        logic [1:0]          pair;
        logic [SQ_REM_W+1:0] rt;
        logic [SQ_REM_W+1:0] tt;
        logic                ge;
        logic [SQ_REM_W-1:0] rem_next;
        logic [ROOT_W-1:0]   root_next;
        logic signed [31:0]  cx_next;
        logic signed [31:0]  cy_next;
        logic signed [31:0]  cz_next;

        if (k == 0)
        begin : g_first
            assign st_valid = pop_valid;
            assign st_item  = pop_item;
            assign rin      = '0;
            assign root_in  = '0;
            assign cxi      = CORDIC_GAIN;
            assign cyi      = '0;
            assign czi      = pop_item.z;
        end
        else
        begin : g_chain
            assign st_valid = sq_valid_reg[k-1];
            assign st_item  = sq_item_reg[k-1];
            assign rin      = sq_rem_reg[k-1];
            assign root_in  = sq_root_reg[k-1];
            assign cxi      = cx_reg[k-1];
            assign cyi      = cy_reg[k-1];
            assign czi      = cz_reg[k-1];
        end

        always_comb
        begin
            v         = {st_item.q, 16'b0};
            pair      = v[PAIR_HI -: 2];
            rt        = {rin, pair};
            tt        = {2'b00, root_in, 2'b01};
            ge        = (rt >= tt);
            rem_next  = ge ? SQ_REM_W'(rt - tt) : rt[SQ_REM_W-1:0];
            root_next = {root_in[ROOT_W-2:0], ge};
            cx_next   = cxi;
            cy_next   = cyi;
            cz_next   = czi;
            if (k < CORDIC_ITERS)
            begin
                if (!czi[31])
                begin
                    cx_next = cxi - (cyi >>> k);
                    cy_next = cyi + (cxi >>> k);
                    cz_next = czi - atan_angle(k);
                end
                else
                begin
                    cx_next = cxi + (cyi >>> k);
                    cy_next = cyi - (cxi >>> k);
                    cz_next = czi + atan_angle(k);
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                sq_valid_reg[k] <= 1'b0;
            end
            else if (adv)
            begin
                sq_valid_reg[k] <= st_valid;
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                sq_item_reg[k] <= st_item;
                sq_rem_reg[k]  <= rem_next;
                sq_root_reg[k] <= root_next;
                cx_reg[k]      <= cx_next;
                cy_reg[k]      <= cy_next;
                cz_reg[k]      <= cz_next;
            end
        end
    end

    // Reciprocal stages: one quotient bit of 2^46 / L per stage.
    logic               dv_valid_reg [DIV_STAGES];
    item_t              dv_item_reg  [DIV_STAGES];
    logic [ROOT_W-1:0]  dv_root_reg  [DIV_STAGES];
    logic [ROOT_W-1:0]  dv_rem_reg   [DIV_STAGES];
    logic [QUO_W-1:0]   dv_quo_reg   [DIV_STAGES];
    logic signed [31:0] dv_c_reg     [DIV_STAGES];
    logic signed [31:0] dv_s_reg     [DIV_STAGES];

    for (genvar j = 0; j < DIV_STAGES; j++)
    begin : g_div
        logic               st_valid;
        item_t              st_item;
        logic [ROOT_W-1:0]  lin;
        logic [ROOT_W-1:0]  rem_in;
        logic [QUO_W-1:0]   quo_in;
        logic signed [31:0] ci;
        logic signed [31:0] si;
        logic [ROOT_W:0]    rs;
        logic               ge;
        logic [ROOT_W-1:0]  rem_next;

        if (j == 0)
        begin : g_first
            assign st_valid = sq_valid_reg[SQRT_STAGES-1];
            assign st_item  = sq_item_reg[SQRT_STAGES-1];
            assign lin      = sq_root_reg[SQRT_STAGES-1];
            assign rem_in   = RECIP_SEED;
            assign quo_in   = '0;
            assign ci       = sq_item_reg[SQRT_STAGES-1].fold ?
                              -cx_reg[SQRT_STAGES-1] : cx_reg[SQRT_STAGES-1];
            assign si       = sq_item_reg[SQRT_STAGES-1].fold ?
                              -cy_reg[SQRT_STAGES-1] : cy_reg[SQRT_STAGES-1];
        end
        else
        begin : g_chain
            assign st_valid = dv_valid_reg[j-1];
            assign st_item  = dv_item_reg[j-1];
            assign lin      = dv_root_reg[j-1];
            assign rem_in   = dv_rem_reg[j-1];
            assign quo_in   = dv_quo_reg[j-1];
            assign ci       = dv_c_reg[j-1];
            assign si       = dv_s_reg[j-1];
        end

        always_comb
        begin
            rs       = {rem_in, 1'b0};
            ge       = (rs >= {1'b0, lin});
            rem_next = ge ? ROOT_W'(rs - {1'b0, lin}) : rs[ROOT_W-1:0];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                dv_valid_reg[j] <= 1'b0;
            end
            else if (adv)
            begin
                dv_valid_reg[j] <= st_valid;
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                dv_item_reg[j] <= st_item;
                dv_root_reg[j] <= lin;
                dv_rem_reg[j]  <= rem_next;
                dv_quo_reg[j]  <= {quo_in[QUO_W-2:0], ge};
                dv_c_reg[j]    <= ci;
                dv_s_reg[j]    <= si;
            end
        end
    end

    // Scale the component magnitudes by the reciprocal.
    item_t              m1_item;
    logic [QUO_W-1:0]   m1_r;
    logic [15:0]        magx;
    logic [15:0]        magy;
    logic [15:0]        magz;

    logic               m1_valid_reg;
    item_t              m1_item_reg;
    logic [54:0]        m1_px_reg;
    logic [54:0]        m1_py_reg;
    logic [54:0]        m1_pz_reg;
    logic signed [31:0] m1_c_reg;
    logic signed [31:0] m1_s_reg;
    logic signed [32:0] m1_t_reg;

    assign m1_item = dv_item_reg[DIV_STAGES-1];
    assign m1_r    = dv_quo_reg[DIV_STAGES-1];
    assign magx    = m1_item.ax[15] ? 16'(-m1_item.ax) : m1_item.ax;
    assign magy    = m1_item.ay[15] ? 16'(-m1_item.ay) : m1_item.ay;
    assign magz    = m1_item.az[15] ? 16'(-m1_item.az) : m1_item.az;

    // Second stage after scaling: rounded, clamped unit components.
    logic               m2_valid_reg;
    logic               m2_zero_reg;
    logic signed [16:0] m2_ux_reg;
    logic signed [16:0] m2_uy_reg;
    logic signed [16:0] m2_uz_reg;
    logic signed [31:0] m2_c_reg;
    logic signed [31:0] m2_s_reg;
    logic signed [32:0] m2_t_reg;

    // Pairwise products of the unit components and sine terms.
    logic               p1_valid_reg;
    logic               p1_zero_reg;
    logic signed [33:0] p1_uu_reg [6];
    logic signed [48:0] p1_su_reg [3];
    logic signed [31:0] p1_c_reg;
    logic signed [32:0] p1_t_reg;

    // Products with t, rounded to Q30.
    logic               p2_valid_reg;
    logic               p2_zero_reg;
    logic signed [36:0] p2_tt_reg [6];
    logic signed [33:0] p2_ss_reg [3];
    logic signed [31:0] p2_c_reg;
    logic signed [66:0] tp [6];
    logic signed [66:0] tr [6];
    logic signed [48:0] sr [3];

    always_comb
    begin
        for (int n = 0; n < 6; n++)
        begin
            tp[n] = p1_t_reg * p1_uu_reg[n];
            tr[n] = tp[n] + 67'sd536870912;
        end
        for (int n = 0; n < 3; n++)
        begin
            sr[n] = p1_su_reg[n] + 49'sd16384;
        end
    end

    // Output register.
    logic               out_valid_reg;
    logic               out_zero_reg;
    logic signed [17:0] ent_reg  [9];
    logic signed [17:0] ent_next [9];

    always_comb
    begin
        ent_next[0] = finish(38'(p2_tt_reg[0]) + 38'(p2_c_reg));
        ent_next[1] = finish(38'(p2_tt_reg[3]) + 38'(p2_ss_reg[2]));
        ent_next[2] = finish(38'(p2_tt_reg[4]) - 38'(p2_ss_reg[1]));
        ent_next[3] = finish(38'(p2_tt_reg[3]) - 38'(p2_ss_reg[2]));
        ent_next[4] = finish(38'(p2_tt_reg[1]) + 38'(p2_c_reg));
        ent_next[5] = finish(38'(p2_tt_reg[5]) + 38'(p2_ss_reg[0]));
        ent_next[6] = finish(38'(p2_tt_reg[4]) + 38'(p2_ss_reg[1]));
        ent_next[7] = finish(38'(p2_tt_reg[5]) - 38'(p2_ss_reg[0]));
        ent_next[8] = finish(38'(p2_tt_reg[2]) + 38'(p2_c_reg));
        if (p2_zero_reg)
        begin
            for (int n = 0; n < 9; n++)
            begin
                ent_next[n] = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m1_valid_reg  <= 1'b0;
            m2_valid_reg  <= 1'b0;
            p1_valid_reg  <= 1'b0;
            p2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            m1_valid_reg  <= dv_valid_reg[DIV_STAGES-1];
            m2_valid_reg  <= m1_valid_reg;
            p1_valid_reg  <= m2_valid_reg;
            p2_valid_reg  <= p1_valid_reg;
            out_valid_reg <= p2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            m1_item_reg <= m1_item;
            m1_px_reg   <= 55'(magx) * 55'(m1_r);
            m1_py_reg   <= 55'(magy) * 55'(m1_r);
            m1_pz_reg   <= 55'(magz) * 55'(m1_r);
            m1_c_reg    <= dv_c_reg[DIV_STAGES-1];
            m1_s_reg    <= dv_s_reg[DIV_STAGES-1];
            m1_t_reg    <= 33'sd1073741824 - 33'(dv_c_reg[DIV_STAGES-1]);

            m2_zero_reg <= m1_item_reg.zero;
            m2_ux_reg   <= unit_comp(m1_item_reg.ax, m1_px_reg, m1_item_reg.unit);
            m2_uy_reg   <= unit_comp(m1_item_reg.ay, m1_py_reg, m1_item_reg.unit);
            m2_uz_reg   <= unit_comp(m1_item_reg.az, m1_pz_reg, m1_item_reg.unit);
            m2_c_reg    <= m1_c_reg;
            m2_s_reg    <= m1_s_reg;
            m2_t_reg    <= m1_t_reg;

            p1_zero_reg  <= m2_zero_reg;
            p1_uu_reg[0] <= m2_ux_reg * m2_ux_reg;
            p1_uu_reg[1] <= m2_uy_reg * m2_uy_reg;
            p1_uu_reg[2] <= m2_uz_reg * m2_uz_reg;
            p1_uu_reg[3] <= m2_ux_reg * m2_uy_reg;
            p1_uu_reg[4] <= m2_ux_reg * m2_uz_reg;
            p1_uu_reg[5] <= m2_uy_reg * m2_uz_reg;
            p1_su_reg[0] <= m2_s_reg * m2_ux_reg;
            p1_su_reg[1] <= m2_s_reg * m2_uy_reg;
            p1_su_reg[2] <= m2_s_reg * m2_uz_reg;
            p1_c_reg     <= m2_c_reg;
            p1_t_reg     <= m2_t_reg;

            p2_zero_reg <= p1_zero_reg;
            for (int n = 0; n < 6; n++)
            begin
                p2_tt_reg[n] <= tr[n][66:30];
            end
            for (int n = 0; n < 3; n++)
            begin
                p2_ss_reg[n] <= sr[n][48:15];
            end
            p2_c_reg <= p1_c_reg;

            out_zero_reg <= p2_zero_reg;
            for (int n = 0; n < 9; n++)
            begin
                ent_reg[n] <= ent_next[n];
            end
        end
    end

    assign result_valid = out_valid_reg;
    assign zero_axis    = out_zero_reg;
    assign m00 = ent_reg[0];
    assign m01 = ent_reg[1];
    assign m02 = ent_reg[2];
    assign m10 = ent_reg[3];
    assign m11 = ent_reg[4];
    assign m12 = ent_reg[5];
    assign m20 = ent_reg[6];
    assign m21 = ent_reg[7];
    assign m22 = ent_reg[8];

    a_zero_matrix: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && zero_axis |-> m00 == 0 && m01 == 0 && m02 == 0 &&
        m10 == 0 && m11 == 0 && m12 == 0 && m20 == 0 && m21 == 0 && m22 == 0)
        else $error("zero axis result carries a nonzero entry");

    a_diag_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> m00 <= 18'sd65536 && m00 >= -18'sd65536 &&
        m11 <= 18'sd65536 && m11 >= -18'sd65536 &&
        m22 <= 18'sd65536 && m22 >= -18'sd65536)
        else $error("diagonal entry outside saturation range");

endmodule
